@@ rtl/dark_block_ratio_check_core_defines.svh @@
// Assertion macros for the checker file of the dark block ratio check.
// No dependencies; take it in with an include of the bare file name.
`ifndef DARK_BLOCK_RATIO_CHECK_CORE_DEFINES_SVH
`define DARK_BLOCK_RATIO_CHECK_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DBRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DBRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dbrc_pkg.sv @@
// Shared types and constants of the dark block ratio check.
// No dependencies; every module of the block imports it.
package dbrc_pkg;

    localparam int COUNT_W   = 21;
    localparam int TENTHS_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // floor(x/3) as (x*DIV3_MUL) >> DIV3_SHIFT, exact for x below 2^17
    localparam int DIV3_MUL   = 43691;
    localparam int DIV3_SHIFT = 17;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERT_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED_FIRST    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SECOND   = 3'd5;

    typedef logic [TENTHS_W-1:0] tenths_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef struct packed {
        tenths_t vert_first;
        tenths_t vert_second;
        tenths_t green_first;
        tenths_t green_second;
        tenths_t red_first;
        tenths_t red_second;
    } thr_bank_t;

    // lowest bits first: width, height, vertical, green, pixel; action on top
    typedef struct packed {
        logic        action;
        logic [7:0]  pixel;
        logic        green;
        logic        vertical;
        logic [10:0] height;
        logic [10:0] width;
    } in_item_t;

    typedef struct packed {
        logic   vertical;
        logic   green;
        count_t first;
        count_t second;
    } fin_t;

    // lowest bits first: accepted, first count, second count
    typedef struct packed {
        count_t second;
        count_t first;
        logic   accepted;
    } result_t;

endpackage

@@ rtl/dbrc_cfg_regs.sv @@
// Threshold register bank of the dark block ratio check.
// Depends on dbrc_pkg.
module dbrc_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dbrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbrc_pkg::TENTHS_W-1:0]  cfg_data,
    output dbrc_pkg::thr_bank_t            thr
);
    import dbrc_pkg::*;

    thr_bank_t thr_reg;
    thr_bank_t thr_next;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VERT_FIRST:   thr_next.vert_first   = cfg_data;
                REG_VERT_SECOND:  thr_next.vert_second  = cfg_data;
                REG_GREEN_FIRST:  thr_next.green_first  = cfg_data;
                REG_GREEN_SECOND: thr_next.green_second = cfg_data;
                REG_RED_FIRST:    thr_next.red_first    = cfg_data;
                REG_RED_SECOND:   thr_next.red_second   = cfg_data;
                default:          thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.vert_first   <= tenths_t'(5);
            thr_reg.vert_second  <= tenths_t'(5);
            thr_reg.green_first  <= tenths_t'(6);
            thr_reg.green_second <= tenths_t'(7);
            thr_reg.red_first    <= tenths_t'(5);
            thr_reg.red_second   <= tenths_t'(5);
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

endmodule

@@ rtl/dbrc_window.sv @@
// Window state of the dark block ratio check: size, bands, raster counters, dark counts.
// Depends on dbrc_pkg.
module dbrc_window
#(
    parameter  int MAX_SIDE = 1024,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
    localparam int TOTAL_W  = 2 * SIDE_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dbrc_pkg::in_item_t   item,
    input  logic                 fire,
    output logic                 is_result,
    output dbrc_pkg::fin_t       fin_next,
    output logic [TOTAL_W-1:0]   total
);
    import dbrc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SIDE);
    localparam int PROD_W = SIDE_W + 17;

    logic [IDX_W-1:0]   col_reg, row_reg;
    logic [IDX_W-1:0]   one_bound_reg, two_bound_reg;
    logic [SIDE_W-1:0]  width_reg, height_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               vert_reg, green_reg;
    count_t             first_reg, second_reg;

    logic [SIDE_W-1:0]  side_w, side_h, side_n;
    logic [PROD_W-1:0]  one_prod, two_prod;
    logic [TOTAL_W-1:0] total_start;
    logic [IDX_W-1:0]   pos;
    logic               band0, band1, band2;
    logic               dark, hit_first, hit_second;
    logic               col_end, row_end, last;
    count_t             first_bumped, second_bumped;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [10:0] v);
        logic [SIDE_W-1:0] r;
        if (v == 11'd0)
            r = SIDE_W'(1);
        else if (32'(v) > MAX_SIDE)
            r = SIDE_W'(MAX_SIDE);
        else
            r = SIDE_W'(v);
        return r;
    endfunction

    always_comb
    begin
        side_w      = clamp_side(item.width);
        side_h      = clamp_side(item.height);
        side_n      = item.vertical ? side_h : side_w;
        one_prod    = PROD_W'(side_n) * PROD_W'(DIV3_MUL);
        two_prod    = PROD_W'({side_n, 1'b0}) * PROD_W'(DIV3_MUL);
        total_start = TOTAL_W'(side_w) * TOTAL_W'(side_h);

        pos   = vert_reg ? row_reg : col_reg;
        band0 = pos < one_bound_reg;
        band1 = !band0 && (pos < two_bound_reg);
        band2 = !band0 && !band1;

        dark       = item.pixel == 8'd0;
        hit_first  = dark && (green_reg ? band0 : band1);
        hit_second = dark && (green_reg ? band1 : band2);

        first_bumped  = (hit_first && first_reg != COUNT_MAX)
                        ? first_reg + COUNT_W'(1) : first_reg;
        second_bumped = (hit_second && second_reg != COUNT_MAX)
                        ? second_reg + COUNT_W'(1) : second_reg;

        col_end = (SIDE_W'(col_reg) + SIDE_W'(1)) >= width_reg;
        row_end = (SIDE_W'(row_reg) + SIDE_W'(1)) >= height_reg;
        last    = col_end && row_end;

        is_result = (item.action == ACT_PIXEL) && last;

        fin_next.vertical = vert_reg;
        fin_next.green    = green_reg;
        fin_next.first    = first_bumped;
        fin_next.second   = second_bumped;
        total             = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            one_bound_reg <= '0;
            two_bound_reg <= '0;
            width_reg     <= SIDE_W'(1);
            height_reg    <= SIDE_W'(1);
            total_reg     <= TOTAL_W'(1);
            vert_reg      <= 1'b0;
            green_reg     <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
        end
        else if (fire)
        begin
            if (item.action == ACT_START)
            begin
                width_reg     <= side_w;
                height_reg    <= side_h;
                total_reg     <= total_start;
                vert_reg      <= item.vertical;
                green_reg     <= item.green;
                one_bound_reg <= IDX_W'(one_prod >> DIV3_SHIFT);
                two_bound_reg <= IDX_W'(two_prod >> DIV3_SHIFT);
                col_reg       <= '0;
                row_reg       <= '0;
                first_reg     <= '0;
                second_reg    <= '0;
            end
            else if (last)
            begin
                col_reg    <= '0;
                row_reg    <= '0;
                first_reg  <= '0;
                second_reg <= '0;
            end
            else
            begin
                first_reg  <= first_bumped;
                second_reg <= second_bumped;
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + IDX_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + IDX_W'(1);
                end
            end
        end
    end

endmodule

@@ rtl/dbrc_judge.sv @@
// Result stages of the dark block ratio check: final counts, ratio test, output register.
// Depends on dbrc_pkg.
module dbrc_judge
#(
    parameter  int MAX_SIDE = 1024,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
    localparam int TOTAL_W  = 2 * SIDE_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fin_load,
    input  dbrc_pkg::fin_t       fin_in,
    input  logic [TOTAL_W-1:0]   total_in,
    input  dbrc_pkg::thr_bank_t  thr,
    output logic                 fin_free,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dbrc_pkg::result_t    res
);
    import dbrc_pkg::*;

    localparam int CMP_W = (COUNT_W + 5 > TOTAL_W + TENTHS_W)
                           ? COUNT_W + 5 : TOTAL_W + TENTHS_W;

    logic               fin_valid_reg, fin_valid_next;
    fin_t               fin_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               out_free;
    tenths_t            t1, t2;
    logic [CMP_W-1:0]   lhs1, lhs2, rhs1, rhs2;

    always_comb
    begin
        out_free = !out_valid_reg || res_ready;
        fin_free = !fin_valid_reg || out_free;

        if (fin_reg.vertical)
        begin
            t1 = thr.vert_first;
            t2 = thr.vert_second;
        end
        else if (fin_reg.green)
        begin
            t1 = thr.green_first;
            t2 = thr.green_second;
        end
        else
        begin
            t1 = thr.red_first;
            t2 = thr.red_second;
        end

        // count*30 as count*32 - count*2
        lhs1 = (CMP_W'(fin_reg.first) << 5) - (CMP_W'(fin_reg.first) << 1);
        lhs2 = (CMP_W'(fin_reg.second) << 5) - (CMP_W'(fin_reg.second) << 1);
        rhs1 = CMP_W'(t1) * CMP_W'(total_reg);
        rhs2 = CMP_W'(t2) * CMP_W'(total_reg);

        out_next.accepted = (lhs1 > rhs1) && (lhs2 > rhs2);
        out_next.first    = fin_reg.first;
        out_next.second   = fin_reg.second;

        fin_valid_next = fin_load ? 1'b1 : (out_free ? 1'b0 : fin_valid_reg);
        out_valid_next = (fin_valid_reg && out_free) ? 1'b1
                         : (res_ready ? 1'b0 : out_valid_reg);

        res_valid = out_valid_reg;
        res       = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_reg   <= fin_in;
            total_reg <= total_in;
        end
        if (fin_valid_reg && out_free)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/dark_block_ratio_check_core.sv @@
// Dark block ratio check: counts dark pixels in two window thirds and tests their ratios.
// Result path: input register, final-count register, output register.
// One item per clock through the single-pass window counter stage, unless a result stalls.
// With both result registers full, the next final pixel waits; other items flow on.
// Reset: rst_n is asynchronous, active low; 1x1 horizontal red window, default thresholds.
module dark_block_ratio_check_core
#(
    parameter int MAX_SIDE = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // width[10:0], height[21:11], vertical[22], lamp_green[23], pixel_value[31:24]
    input  logic [dbrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accepted[0], first_dark_count[21:1], second_dark_count[42:22], zero[47:43]
    output logic [dbrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dbrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbrc_pkg::TENTHS_W-1:0]     cfg_data
);
    import dbrc_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int TOTAL_W = 2 * SIDE_W;

    logic               in_valid_reg, in_valid_next;
    in_item_t           item_reg;
    logic               fire, is_result, fin_free;
    fin_t               fin_next;
    logic [TOTAL_W-1:0] total;
    thr_bank_t          thr;
    result_t            res;

    assign fire          = in_valid_reg && (!is_result || fin_free);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(res);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= in_item_t'({s_axis_tuser, s_axis_tdata});
        end
    end

    dbrc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    dbrc_window #(.MAX_SIDE(MAX_SIDE)) u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_reg),
        .fire      (fire),
        .is_result (is_result),
        .fin_next  (fin_next),
        .total     (total)
    );

    dbrc_judge #(.MAX_SIDE(MAX_SIDE)) u_judge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_load  (fire && is_result),
        .fin_in    (fin_next),
        .total_in  (total),
        .thr       (thr),
        .fin_free  (fin_free),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

endmodule

@@ rtl/dbrc_checker.sv @@
// Port-level assertion checker for dark_block_ratio_check_core, bound to the top level.
// Depends on dbrc_pkg and dark_block_ratio_check_core_defines.svh.
`include "dark_block_ratio_check_core_defines.svh"

module dbrc_checker
#(
    parameter int MAX_SIDE = 1024
)
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [dbrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input logic [0:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dbrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [dbrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [dbrc_pkg::TENTHS_W-1:0]     cfg_data
);
    import dbrc_pkg::*;

    logic [31:0] count_sum;

    assign count_sum = 32'(m_axis_tdata[21:1]) + 32'(m_axis_tdata[42:22]);

    `DBRC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `DBRC_ASSERT_IMPL(a_pass_needs_dark, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], (m_axis_tdata[21:1] != '0) && (m_axis_tdata[42:22] != '0), "window passed with an empty band count")
    `DBRC_ASSERT_IMPL(a_count_bound, clk, rst_n, m_axis_tvalid, count_sum <= 32'(MAX_SIDE * MAX_SIDE), "band counts exceed the window size")
    `DBRC_ASSERT_IMPL(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:43] == '0, "result padding bits not zero")

endmodule

bind dark_block_ratio_check_core dbrc_checker #(.MAX_SIDE(MAX_SIDE)) u_dbrc_checker (.*);
